// ----- hdl/ucdp_pkg.sv -----
// Shared types and constants for the USB configuration descriptor parser.
`default_nettype none

package ucdp_pkg;

  // Most results one item can cause: two extra bytes plus the end status
  localparam int MAX_RES = 3;
  localparam int N_W     = 2;
  localparam int Q_DEPTH = 4;
  localparam int QP_W    = 2;

  // Descriptor type codes
  localparam logic [7:0] DT_CONFIG   = 8'd2;
  localparam logic [7:0] DT_IFACE    = 8'd4;
  localparam logic [7:0] DT_ENDPOINT = 8'd5;

  typedef enum logic [1:0] {
    KIND_IFACE    = 2'd0,
    KIND_ENDPOINT = 2'd1,
    KIND_EXTRA    = 2'd2,
    KIND_END      = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] byte_req;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [7:0]  number;
    logic [7:0]  class_code;
    logic [7:0]  subclass;
    logic [7:0]  protocol;
    logic [15:0] pkt_size;
    logic [7:0]  endpoint_total;
    logic        status;
    logic [4:0]  interface_total;
    logic [7:0]  cfg_val;
    logic        final_res;
  } res_item_t;

  // Results produced by one accepted item, in order, row 0 first
  typedef struct packed {
    logic [N_W-1:0]               n;
    res_item_t [MAX_RES-1:0]      row;
  } push_t;

endpackage

`default_nettype wire

// ----- hdl/ucdp_parser.sv -----
// Parser state and the per-byte step logic producing up to three results.
`default_nettype none

module ucdp_parser import ucdp_pkg::*; #(
  parameter int MAX_IFACES = 16,
  parameter int MAX_EPS    = 16,
  parameter int MAX_EXTRA  = 256,
  parameter int MAX_TOTAL  = 1024
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     take_i,
  input  wire in_item_t in_item_i,
  output push_t         push_o
);

  localparam int OFF_W = $clog2(MAX_TOTAL + 1);
  localparam int IFS_W = $clog2(MAX_IFACES + 1);
  localparam int EPS_W = $clog2(MAX_EPS + 1);
  localparam int XU_W  = $clog2(MAX_EXTRA + 1);
  localparam int IDX_W = (MAX_IFACES > 1) ? $clog2(MAX_IFACES) : 1;

  logic [OFF_W-1:0] off_q, off_d;
  logic [15:0]      tot_q, tot_d;
  logic [7:0]       ifd_q, ifd_d;
  logic [7:0]       cfg_q, cfg_d;
  logic [7:0]       dlen_q, dlen_d;
  logic [7:0]       dkind_q, dkind_d;
  logic [7:0]       pos_q, pos_d;
  logic [47:0]      cap_q, cap_d;
  logic             open_q, open_d;
  logic [IFS_W-1:0] ifs_q, ifs_d;
  logic [7:0]       ifnum_q [MAX_IFACES];
  logic             store_if;
  logic             dup_if;
  logic [7:0]       epx_q, epx_d;
  logic [EPS_W-1:0] eps_q, eps_d;
  logic [XU_W-1:0]  xused_q, xused_d;
  logic             fault_q, fault_d;
  logic             alt_q, alt_d;
  logic             pass_q, pass_d;

  function automatic res_item_t extra_row(logic [3:0] slot, logic [7:0] val);
    res_item_t r;
    r        = '0;
    r.kind   = KIND_EXTRA;
    r.slot   = slot;
    r.number = val;
    return r;
  endfunction

  // interface number already stored in this set; byte 0 of the capture holds it
  always_comb begin
    dup_if = 1'b0;
    for (int i = 0; i < MAX_IFACES; i++) begin
      if (IFS_W'(i) < ifs_q && ifnum_q[i] == cap_q[7:0]) dup_if = 1'b1;
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic        last;
    logic [16:0] off_x;
    logic [16:0] tot_x;
    logic [16:0] start_x;
    logic [47:0] capn;
    logic [3:0]  slot_cur;
    logic [1:0]  nt;
    logic        fault_e;
    res_item_t   r0;
    res_item_t   r1;
    res_item_t   rs;

    off_d    = off_q;
    tot_d    = tot_q;
    ifd_d    = ifd_q;
    cfg_d    = cfg_q;
    dlen_d   = dlen_q;
    dkind_d  = dkind_q;
    pos_d    = pos_q;
    cap_d    = cap_q;
    open_d   = open_q;
    ifs_d    = ifs_q;
    store_if = 1'b0;
    epx_d    = epx_q;
    eps_d    = eps_q;
    xused_d  = xused_q;
    fault_d  = fault_q;
    alt_d    = alt_q;
    pass_d   = pass_q;

    b        = in_item_i.byte_req;
    last     = in_item_i.last;
    off_x    = 17'(off_q);
    tot_x    = {1'b0, tot_q};
    start_x  = off_x - 17'd1;
    slot_cur = 4'(ifs_q - IFS_W'(1));
    nt       = '0;
    fault_e  = 1'b0;
    r0       = '0;
    r1       = '0;
    rs       = '0;

    // fields of the current descriptor, bytes 2..7, with this byte merged in
    capn = cap_q;
    if (pos_q >= 8'd2 && pos_q < 8'd8) begin
      capn[{pos_q[2:0] - 3'd2, 3'b000} +: 8] = b;
    end

    if (take_i) begin
      if (!fault_q) begin
        if (last && (off_x < 17'd8 || off_x + 17'd1 != tot_x)) begin
          fault_d = 1'b1;
        end else if (off_x >= 17'd4 && off_x >= tot_x) begin
          fault_d = 1'b1;
        end else begin
          off_d = OFF_W'(off_x + 17'd1);
          if (pos_q == 8'd0) begin
            dlen_d = b;
            pos_d  = 8'd1;
          end else begin
            if (pos_q == 8'd1) begin
              dkind_d = b;
              pass_d  = 1'b0;
              if (start_x == 17'd0) begin
                if (b != DT_CONFIG || dlen_q < 8'd9) fault_d = 1'b1;
              end else if (dlen_q < 8'd2 || start_x + 17'(dlen_q) > tot_x ||
                           b == DT_CONFIG) begin
                fault_d = 1'b1;
              end else if (b == DT_IFACE) begin
                if (open_q && 8'(eps_q) != epx_q) fault_d = 1'b1;
                open_d = 1'b0;
                alt_d  = 1'b0;
                if (dlen_q < 8'd9) fault_d = 1'b1;
              end else if (b == DT_ENDPOINT) begin
                if (!alt_q && (!open_q || dlen_q < 8'd7)) fault_d = 1'b1;
              end else if (open_q) begin
                if (13'(dlen_q) > 13'(MAX_EXTRA) - 13'(xused_q)) begin
                  fault_d = 1'b1;
                end else begin
                  xused_d = XU_W'(13'(xused_q) + 13'(dlen_q));
                  pass_d  = 1'b1;
                  r0      = extra_row(slot_cur, dlen_q);
                  r1      = extra_row(slot_cur, b);
                  nt      = 2'd2;
                end
              end
            end else begin
              cap_d = capn;
              if (off_x == 17'(pos_q)) begin
                // still inside the header
                if (pos_q == 8'd3) begin
                  tot_d = capn[15:0];
                  if (capn[15:0] < 16'd9 || 17'(capn[15:0]) > 17'(MAX_TOTAL) ||
                      {8'd0, dlen_q} > capn[15:0]) begin
                    fault_d = 1'b1;
                  end
                end else if (pos_q == 8'd4) begin
                  ifd_d = b;
                end else if (pos_q == 8'd5) begin
                  cfg_d = b;
                end
              end else if (dkind_q == DT_IFACE && pos_q == 8'd8) begin
                if (32'(capn[23:16]) > MAX_EPS) begin
                  fault_d = 1'b1;
                end else if (capn[15:8] != 8'd0) begin
                  alt_d = 1'b1;
                end else if (dup_if) begin
                  fault_d = 1'b1;
                end else if (8'(ifs_q) >= ifd_q || 32'(ifs_q) >= MAX_IFACES) begin
                  fault_d = 1'b1;
                end else begin
                  store_if            = 1'b1;
                  ifs_d               = ifs_q + IFS_W'(1);
                  open_d              = 1'b1;
                  epx_d               = capn[23:16];
                  eps_d               = '0;
                  xused_d             = '0;
                  r0.kind             = KIND_IFACE;
                  r0.slot             = 4'(ifs_q);
                  r0.number           = capn[7:0];
                  r0.class_code       = capn[31:24];
                  r0.subclass         = capn[39:32];
                  r0.protocol         = capn[47:40];
                  r0.endpoint_total   = capn[23:16];
                  nt                  = 2'd1;
                end
              end else if (dkind_q == DT_ENDPOINT && pos_q == 8'd6 && !alt_q) begin
                if (8'(eps_q) >= epx_q || 32'(eps_q) >= MAX_EPS) begin
                  fault_d = 1'b1;
                end else if (capn[3:0] == 4'd0 || capn[26:16] == 11'd0 ||
                             capn[9:8] == 2'd0) begin
                  fault_d = 1'b1;
                end else begin
                  eps_d         = eps_q + EPS_W'(1);
                  r0.kind       = KIND_ENDPOINT;
                  r0.slot       = slot_cur;
                  r0.number     = capn[7:0];
                  r0.class_code = capn[15:8];
                  r0.subclass   = capn[39:32];
                  r0.pkt_size   = capn[31:16];
                  nt            = 2'd1;
                end
              end else if (pass_q) begin
                r0 = extra_row(slot_cur, b);
                nt = 2'd1;
              end
            end
            if (fault_d) begin
              nt = '0;
            end else begin
              pos_d = (9'(pos_q) + 9'd1 >= 9'(dlen_q)) ? 8'd0 : pos_q + 8'd1;
            end
          end
        end
      end

      if (last) begin
        fault_e = fault_d;
        if (!fault_d) begin
          if (open_d && 8'(eps_d) != epx_d) fault_e = 1'b1;
          if (8'(ifs_d) != ifd_d) fault_e = 1'b1;
        end
        rs.kind            = KIND_END;
        rs.status          = fault_e;
        rs.interface_total = 5'(ifs_d);
        rs.cfg_val         = cfg_d;
        // back to the reset state for the next set
        off_d   = '0;
        tot_d   = '0;
        ifd_d   = '0;
        cfg_d   = '0;
        dlen_d  = '0;
        dkind_d = '0;
        pos_d   = '0;
        open_d  = 1'b0;
        ifs_d   = '0;
        epx_d   = '0;
        eps_d   = '0;
        xused_d = '0;
        fault_d = 1'b0;
        alt_d   = 1'b0;
        pass_d  = 1'b0;
      end
    end

    if (last) begin
      rs.final_res = 1'b1;
    end else if (nt == 2'd1) begin
      r0.final_res = 1'b1;
    end else if (nt == 2'd2) begin
      r1.final_res = 1'b1;
    end

    push_o = '0;
    case (nt)
      2'd0: begin
        push_o.row[0] = rs;
      end
      2'd1: begin
        push_o.row[0] = r0;
        push_o.row[1] = rs;
      end
      2'd2: begin
        push_o.row[0] = r0;
        push_o.row[1] = r1;
        push_o.row[2] = rs;
      end
      default: begin
        push_o.row[0] = rs;
      end
    endcase
    push_o.n = (take_i && last) ? nt + 2'd1 : nt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      tot_q   <= '0;
      ifd_q   <= '0;
      cfg_q   <= '0;
      dlen_q  <= '0;
      dkind_q <= '0;
      pos_q   <= '0;
      open_q  <= 1'b0;
      ifs_q   <= '0;
      epx_q   <= '0;
      eps_q   <= '0;
      xused_q <= '0;
      fault_q <= 1'b0;
      alt_q   <= 1'b0;
      pass_q  <= 1'b0;
    end else begin
      off_q   <= off_d;
      tot_q   <= tot_d;
      ifd_q   <= ifd_d;
      cfg_q   <= cfg_d;
      dlen_q  <= dlen_d;
      dkind_q <= dkind_d;
      pos_q   <= pos_d;
      open_q  <= open_d;
      ifs_q   <= ifs_d;
      epx_q   <= epx_d;
      eps_q   <= eps_d;
      xused_q <= xused_d;
      fault_q <= fault_d;
      alt_q   <= alt_d;
      pass_q  <= pass_d;
    end
  end

  // only entries below the stored count are looked at, so no clear per set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_IFACES; i++) ifnum_q[i] <= '0;
    end else if (store_if) begin
      ifnum_q[IDX_W'(ifs_q)] <= cap_q[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    cap_q <= cap_d;
  end

endmodule

`default_nettype wire

// ----- hdl/ucdp_res_queue.sv -----
// Result queue: takes up to three results per cycle, hands out one per cycle while out_ready_i is high.
`default_nettype none

module ucdp_res_queue import ucdp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire push_t     push_i,
  output logic           ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output res_item_t      out_item_o
);

  res_item_t       mem_q [Q_DEPTH];
  logic [QP_W-1:0] wr_q, wr_d;
  logic [QP_W-1:0] rd_q, rd_d;
  logic [QP_W:0]   cnt_q, cnt_d;
  logic            pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  // room for the worst case of one item
  assign ready_o     = (cnt_q <= (QP_W + 1)'(Q_DEPTH - MAX_RES));

  always_comb begin
    wr_d  = wr_q + QP_W'(push_i.n);
    rd_d  = rd_q + QP_W'(pop);
    cnt_d = cnt_q + (QP_W + 1)'(push_i.n) - (QP_W + 1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (N_W'(i) < push_i.n) begin
        mem_q[wr_q + QP_W'(i)] <= push_i.row[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/usb_config_descriptor_parser_core.sv -----
// USB configuration descriptor parser, top level.
// Takes one descriptor byte per clock while in_ready_o is high and turns it
// into interface, endpoint and extra-byte records plus an end status on the
// byte flagged last. Each byte is handled by the combinational step logic
// against the parser registers; its results (none, one, two or three) are
// written into a four-entry result queue in the cycle after. The output side
// drains one result per cycle while out_ready_i is high, and in_ready_o
// drops while more than one result is still queued. With the output never
// stalled, bytes that cause at most one result flow at one per cycle.
`default_nettype none

module usb_config_descriptor_parser_core import ucdp_pkg::*; #(
  parameter int MAX_IFACES = 16,
  parameter int MAX_EPS    = 16,
  parameter int MAX_EXTRA  = 256,
  parameter int MAX_TOTAL  = 1024
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output res_item_t     out_item_o
);

  logic  take;
  push_t push;

  assign take = in_valid_i && in_ready_o;

  ucdp_parser #(
    .MAX_IFACES (MAX_IFACES),
    .MAX_EPS    (MAX_EPS),
    .MAX_EXTRA  (MAX_EXTRA),
    .MAX_TOTAL  (MAX_TOTAL)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .in_item_i (in_item_i),
    .push_o    (push)
  );

  ucdp_res_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ----- hdl/ucdp_checker.sv -----
// Port-level checks on the parser's result stream, bound to the top level.
`default_nettype none

module ucdp_checker import ucdp_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire res_item_t out_item_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // end status is always the closing result of its item
  a_end_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KIND_END |-> out_item_o.final_res)
    else $error("end status without final flag");

  // status fields only on the end status item
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind != KIND_END |->
      !out_item_o.status && out_item_o.interface_total == 5'd0 &&
      out_item_o.cfg_val == 8'd0)
    else $error("status fields set on a record");

  // emitted endpoints passed the address and packet size checks
  a_ep_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KIND_ENDPOINT |->
      out_item_o.number[3:0] != 4'd0 && out_item_o.pkt_size[10:0] != 11'd0)
    else $error("invalid endpoint record emitted");

endmodule

bind usb_config_descriptor_parser_core ucdp_checker u_checker (.*);

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the USB configuration descriptor parser core.
`timescale 1ns / 100ps

module tb;
  import ucdp_pkg::*;

  localparam int MAX_IFACES = 16;
  localparam int MAX_EPS    = 16;
  localparam int MAX_EXTRA  = 256;
  localparam int MAX_TOTAL  = 1024;
  localparam int RAND_BYTES = 650;
  localparam int LIMIT      = 400000;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  res_item_t out_item_o;

  usb_config_descriptor_parser_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  int  cycle_count = 0;
  int  err_count   = 0;
  int  bytes_sent  = 0;
  int  sets_sent   = 0;
  int  checked     = 0;
  int  kind_seen[4];
  int  malformed   = 0;
  // no idling on either side while set
  logic calm = 1'b0;

  // ---------------------------------------------------------------------------
  // Parser mirror: state and the records it predicts
  // ---------------------------------------------------------------------------
  logic [10:0]  pr_offset;
  logic [15:0]  pr_total;
  logic [7:0]   pr_if_decl, pr_cfg, pr_dlen, pr_dtype, pr_dpos, pr_ep_exp;
  logic [63:0]  pr_fields;
  logic         pr_open, pr_fault, pr_alt_skip, pr_passing;
  logic [4:0]   pr_if_stored, pr_ep_seen;
  logic [255:0] pr_seen;
  logic [8:0]   pr_extra;
  res_item_t    step_res[$];
  res_item_t    records_due[$];

  function automatic void clear_parser();
    pr_offset    = '0;
    pr_total     = '0;
    pr_if_decl   = '0;
    pr_cfg       = '0;
    pr_dlen      = '0;
    pr_dtype     = '0;
    pr_dpos      = '0;
    pr_fields    = '0;
    pr_open      = 1'b0;
    pr_if_stored = '0;
    pr_seen      = '0;
    pr_ep_exp    = '0;
    pr_ep_seen   = '0;
    pr_extra     = '0;
    pr_fault     = 1'b0;
    pr_alt_skip  = 1'b0;
    pr_passing   = 1'b0;
  endfunction

  function automatic void emit_passthru(logic [7:0] v);
    res_item_t r;
    r        = '0;
    r.kind   = KIND_EXTRA;
    r.slot   = 4'(pr_if_stored - 5'd1);
    r.number = v;
    step_res.push_back(r);
  endfunction

  function automatic void close_interface();
    logic [7:0] num, alt, neps;
    res_item_t  r;
    num  = pr_fields[7:0];
    alt  = pr_fields[15:8];
    neps = pr_fields[23:16];
    // endpoint count is checked ahead of the alternate setting
    if (neps > MAX_EPS) pr_fault = 1'b1;
    else if (alt != 8'd0) pr_alt_skip = 1'b1;
    else if (pr_seen[num]) pr_fault = 1'b1;
    else if (pr_if_stored >= pr_if_decl || pr_if_stored >= MAX_IFACES) pr_fault = 1'b1;
    else begin
      pr_seen[num]     = 1'b1;
      pr_if_stored     = pr_if_stored + 5'd1;
      pr_open          = 1'b1;
      pr_ep_exp        = neps;
      pr_ep_seen       = '0;
      pr_extra         = '0;
      r                = '0;
      r.kind           = KIND_IFACE;
      r.slot           = 4'(pr_if_stored - 5'd1);
      r.number         = num;
      r.class_code     = pr_fields[31:24];
      r.subclass       = pr_fields[39:32];
      r.protocol       = pr_fields[47:40];
      r.endpoint_total = neps;
      step_res.push_back(r);
    end
  endfunction

  function automatic void close_endpoint();
    logic [7:0]  addr, attr;
    logic [15:0] mp;
    res_item_t   r;
    addr = pr_fields[7:0];
    attr = pr_fields[15:8];
    mp   = pr_fields[31:16];
    if (pr_ep_seen >= pr_ep_exp || pr_ep_seen >= MAX_EPS) pr_fault = 1'b1;
    else if (addr[3:0] == 4'd0 || mp[10:0] == 11'd0 || attr[1:0] == 2'd0) pr_fault = 1'b1;
    else begin
      pr_ep_seen   = pr_ep_seen + 5'd1;
      r            = '0;
      r.kind       = KIND_ENDPOINT;
      r.slot       = 4'(pr_if_stored - 5'd1);
      r.number     = addr;
      r.class_code = attr;
      r.subclass   = pr_fields[39:32];
      r.pkt_size   = mp;
      step_res.push_back(r);
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    logic [10:0] off, start;
    logic [7:0]  pos;
    off       = pr_offset;
    pos       = pr_dpos;
    pr_offset = off + 11'd1;
    if (pos == 8'd0) begin
      pr_dlen = b;
      pr_dpos = 8'd1;
      return;
    end
    if (pos == 8'd1) begin
      start      = off - 11'd1;
      pr_dtype   = b;
      pr_fields  = '0;
      pr_passing = 1'b0;
      if (start == 11'd0) begin
        if (b != DT_CONFIG || pr_dlen < 8'd9) pr_fault = 1'b1;
      end else if (pr_dlen < 8'd2 || 32'(start) + 32'(pr_dlen) > 32'(pr_total)
                   || b == DT_CONFIG) begin
        pr_fault = 1'b1;
      end else if (b == DT_IFACE) begin
        if (pr_open && pr_ep_seen != pr_ep_exp) pr_fault = 1'b1;
        pr_open     = 1'b0;
        pr_alt_skip = 1'b0;
        if (pr_dlen < 8'd9) pr_fault = 1'b1;
      end else if (b == DT_ENDPOINT) begin
        if (!pr_alt_skip && (!pr_open || pr_dlen < 8'd7)) pr_fault = 1'b1;
      end else if (pr_open) begin
        // whole descriptor must fit in what is left of the extra budget
        if (32'(pr_dlen) > MAX_EXTRA - 32'(pr_extra)) pr_fault = 1'b1;
        else begin
          pr_extra   = pr_extra + 9'(pr_dlen);
          pr_passing = 1'b1;
          emit_passthru(pr_dlen);
          emit_passthru(b);
        end
      end
    end else begin
      if (pos < 8'd10) pr_fields[8 * (int'(pos) - 2) +: 8] = b;
      if (off == 11'(pos)) begin
        // still inside the configuration header
        if (pos == 8'd3) begin
          pr_total = pr_fields[15:0];
          if (pr_total < 16'd9 || pr_total > MAX_TOTAL || 16'(pr_dlen) > pr_total)
            pr_fault = 1'b1;
        end else if (pos == 8'd4) pr_if_decl = b;
        else if (pos == 8'd5) pr_cfg = b;
      end else if (pr_dtype == DT_IFACE && pos == 8'd8) close_interface();
      else if (pr_dtype == DT_ENDPOINT && pos == 8'd6 && !pr_alt_skip) close_endpoint();
      else if (pr_passing) emit_passthru(b);
    end
    if (pr_fault) begin
      step_res.delete();
      return;
    end
    pr_dpos = (32'(pos) + 32'd1 >= 32'(pr_dlen)) ? 8'd0 : pos + 8'd1;
  endfunction

  function automatic void predict_byte(in_item_t it);
    res_item_t r;
    step_res.delete();
    if (!pr_fault) begin
      if (it.last && (pr_offset < 11'd8 || 32'(pr_offset) + 32'd1 != 32'(pr_total)))
        pr_fault = 1'b1;
      else if (pr_offset >= 11'd4 && pr_offset >= pr_total)
        pr_fault = 1'b1;
      else
        parse_byte(it.byte_req);
    end
    if (it.last) begin
      if (!pr_fault) begin
        if (pr_open && pr_ep_seen != pr_ep_exp) pr_fault = 1'b1;
        if (8'(pr_if_stored) != pr_if_decl) pr_fault = 1'b1;
      end
      r                 = '0;
      r.kind            = KIND_END;
      r.status          = pr_fault;
      r.interface_total = pr_if_stored;
      r.cfg_val         = pr_cfg;
      step_res.push_back(r);
      clear_parser();
    end
    if (step_res.size() > 0) begin
      r           = step_res.pop_back();
      r.final_res = 1'b1;
      step_res.push_back(r);
    end
    foreach (step_res[i]) records_due.push_back(step_res[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                checked, what, got, want));
  endtask

  task automatic check_record(input res_item_t got);
    res_item_t want;
    if (records_due.size() == 0) begin
      report_mismatch($sformatf("result of kind %0d with none expected", got.kind));
      return;
    end
    want = records_due.pop_front();
    check_field("kind", 16'(got.kind), 16'(want.kind));
    check_field("slot", 16'(got.slot), 16'(want.slot));
    check_field("number", 16'(got.number), 16'(want.number));
    check_field("class_code", 16'(got.class_code), 16'(want.class_code));
    check_field("subclass", 16'(got.subclass), 16'(want.subclass));
    check_field("protocol", 16'(got.protocol), 16'(want.protocol));
    check_field("pkt_size", got.pkt_size, want.pkt_size);
    check_field("endpoint_total", 16'(got.endpoint_total), 16'(want.endpoint_total));
    check_field("status", 16'(got.status), 16'(want.status));
    check_field("interface_total", 16'(got.interface_total), 16'(want.interface_total));
    check_field("cfg_val", 16'(got.cfg_val), 16'(want.cfg_val));
    check_field("final_res", 16'(got.final_res), 16'(want.final_res));
    kind_seen[want.kind]++;
    if (want.kind == KIND_END && want.status) malformed++;
    checked++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) check_record(out_item_o);
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 35);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Descriptor set construction
  // ---------------------------------------------------------------------------
  logic [7:0] set_q[$];
  int         desc_at[$];

  function automatic logic [7:0] rand_type();
    logic [7:0] t;
    t = 8'($urandom_range(255));
    if (t == DT_CONFIG || t == DT_IFACE || t == DT_ENDPOINT) t = 8'h24;
    return t;
  endfunction

  function automatic void put_header(logic [7:0] cfg, logic [7:0] pad);
    set_q.delete();
    desc_at.delete();
    desc_at.push_back(0);
    set_q.push_back(8'd9);
    set_q.push_back(DT_CONFIG);
    set_q.push_back(8'd0);
    set_q.push_back(8'd0);
    set_q.push_back(8'd0);
    set_q.push_back(cfg);
    set_q.push_back(pad);
    set_q.push_back(pad);
    set_q.push_back(pad);
  endfunction

  function automatic void seal_set(int n_if);
    int total;
    total    = set_q.size();
    set_q[2] = 8'(total);
    set_q[3] = 8'(total >> 8);
    set_q[4] = 8'(n_if);
  endfunction

  function automatic void put_iface(logic [7:0] num, logic [7:0] alt, logic [7:0] neps,
                                    logic [7:0] cls, logic [7:0] sub, logic [7:0] proto);
    desc_at.push_back(set_q.size());
    set_q.push_back(8'd9);
    set_q.push_back(DT_IFACE);
    set_q.push_back(num);
    set_q.push_back(alt);
    set_q.push_back(neps);
    set_q.push_back(cls);
    set_q.push_back(sub);
    set_q.push_back(proto);
    set_q.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void put_endpoint(logic [7:0] addr, logic [7:0] attr,
                                       logic [15:0] mp, logic [7:0] interval);
    desc_at.push_back(set_q.size());
    set_q.push_back(8'd7);
    set_q.push_back(DT_ENDPOINT);
    set_q.push_back(addr);
    set_q.push_back(attr);
    set_q.push_back(mp[7:0]);
    set_q.push_back(mp[15:8]);
    set_q.push_back(interval);
  endfunction

  function automatic void put_rand_endpoint();
    logic [7:0]  addr, attr;
    logic [15:0] mp;
    addr = 8'($urandom_range(255));
    attr = 8'($urandom_range(255));
    mp   = 16'($urandom_range(65535));
    if (addr[3:0] == 4'd0) addr[3:0] = 4'($urandom_range(1, 15));
    if (attr[1:0] == 2'd0) attr[1:0] = 2'($urandom_range(1, 3));
    if (mp[10:0] == 11'd0) mp[0] = 1'b1;
    put_endpoint(addr, attr, mp, 8'($urandom_range(255)));
  endfunction

  function automatic void put_other(int len, logic [7:0] typ);
    desc_at.push_back(set_q.size());
    set_q.push_back(8'(len));
    set_q.push_back(typ);
    for (int i = 2; i < len; i++) set_q.push_back(8'($urandom_range(255)));
  endfunction

  // Mostly well-formed set with random content; a few deliberate faults
  function automatic void build_set();
    int           n_if, neps, decl, alts;
    logic [7:0]   num, prev;
    logic [255:0] used;
    used = '0;
    prev = '0;
    put_header(8'($urandom_range(255)), 8'($urandom_range(255)));
    if ($urandom_range(9) == 0) put_other($urandom_range(2, 8), rand_type());
    if ($urandom_range(24) == 0) put_rand_endpoint();
    n_if = ($urandom_range(19) == 0) ? $urandom_range(15, 17) : $urandom_range(0, 3);
    for (int i = 0; i < n_if; i++) begin
      num = 8'($urandom_range(255));
      if (i > 0 && $urandom_range(24) == 0) num = prev;
      else while (used[num]) num = num + 8'd1;
      used[num] = 1'b1;
      prev      = num;
      if (n_if > 4) neps = $urandom_range(0, 1);
      else if ($urandom_range(29) == 0) neps = 16 + $urandom_range(1);
      else neps = $urandom_range(0, 2);
      decl = neps;
      if ($urandom_range(19) == 0) decl = neps + 1;
      else if (neps > 0 && $urandom_range(19) == 0) decl = neps - 1;
      put_iface(num, 8'd0, 8'(decl), 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
      if ($urandom_range(2) == 0) put_other($urandom_range(2, 12), rand_type());
      for (int e = 0; e < neps; e++) begin
        put_rand_endpoint();
        if ($urandom_range(9) == 0) put_other($urandom_range(2, 6), rand_type());
      end
      // alternate setting: skipped as a whole by the parser
      if ($urandom_range(4) == 0) begin
        alts = $urandom_range(0, 2);
        put_iface(num, 8'($urandom_range(1, 255)), 8'(alts), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
        for (int e = 0; e < alts; e++) put_rand_endpoint();
        if ($urandom_range(1) == 0) put_other($urandom_range(2, 8), rand_type());
      end
    end
    seal_set(n_if);
  endfunction

  function automatic void mutate_set();
    int k;
    k = desc_at[$urandom_range(desc_at.size() - 1)];
    case ($urandom_range(1, 9))
      1: begin
        k        = $urandom_range(set_q.size() - 1);
        set_q[k] = set_q[k] ^ (8'd1 << $urandom_range(7));
      end
      2: if (set_q.size() > 1) void'(set_q.pop_back());
      3: set_q.push_back(8'($urandom_range(255)));
      4: set_q[4] = ($urandom_range(1) == 0) ? set_q[4] + 8'd1 : set_q[4] - 8'd1;
      5: begin
        k = $urandom_range(1, set_q.size());
        while (set_q.size() > k) void'(set_q.pop_back());
      end
      6: begin
        set_q[2] = 8'($urandom_range(255));
        set_q[3] = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(4));
      end
      7: set_q[k] = 8'($urandom_range(12));
      8: if (k + 1 < set_q.size()) begin
        case ($urandom_range(2))
          0:       set_q[k + 1] = DT_CONFIG;
          1:       set_q[k + 1] = DT_IFACE;
          default: set_q[k + 1] = DT_ENDPOINT;
        endcase
      end
      default: if (k + 5 < set_q.size()) begin
        case ($urandom_range(2))
          0: set_q[k + 2] = set_q[k + 2] & 8'hF0;
          1: set_q[k + 3] = set_q[k + 3] & 8'hFC;
          default: begin
            set_q[k + 4] = 8'd0;
            set_q[k + 5] = set_q[k + 5] & 8'hF8;
          end
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic fin);
    in_item_t it;
    it.byte_req = b;
    it.last     = fin;
    while (!calm && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predict_byte(it);
    bytes_sent++;
  endtask

  task automatic send_set();
    foreach (set_q[i]) send_byte(set_q[i], i == set_q.size() - 1);
    sets_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_header_only();
    put_header(8'hA5, 8'h00);
    seal_set(0);
    send_set();
    // a set that ends on its first byte
    set_q.delete();
    set_q.push_back(8'hFF);
    send_set();
  endtask

  // One interface, one class-specific descriptor, one endpoint and a lone
  // trailing byte, with the fields set from fill at its low or high extreme
  task automatic test_extreme_fields(input logic [7:0] fill);
    put_header(fill, fill);
    put_iface(fill, 8'd0, 8'd1, fill, fill, fill);
    put_other(3, 8'h24);
    put_endpoint(fill | 8'h01, fill | 8'h01, {fill, fill | 8'h01}, fill);
    set_q.push_back(fill);
    seal_set(1);
    send_set();
  endtask

  // Extra bytes filled to exactly the budget, then one descriptor past it
  task automatic test_extra_limit();
    put_header(8'h3C, 8'h00);
    put_iface(8'd3, 8'd0, 8'd0, 8'h01, 8'h02, 8'h03);
    put_other(200, 8'h24);
    put_other(56, 8'h25);
    put_other(2, 8'h26);
    seal_set(1);
    send_set();
  endtask

  task automatic test_random_sets();
    int first;
    first = bytes_sent;
    while (bytes_sent - first < RAND_BYTES) begin
      calm <= (bytes_sent - first >= 400 && bytes_sent - first < 600);
      if ($urandom_range(9) == 0) begin
        set_q.delete();
        repeat ($urandom_range(1, 14)) set_q.push_back(8'($urandom_range(255)));
      end else begin
        build_set();
        if ($urandom_range(99) < 30) mutate_set();
      end
      send_set();
    end
    calm <= 1'b0;
  endtask

  initial begin
    clear_parser();
    foreach (kind_seen[i]) kind_seen[i] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_header_only();
    test_extreme_fields(8'h00);
    test_extreme_fields(8'hFF);
    test_extra_limit();
    test_random_sets();

    in_valid_i <= 1'b0;
    while (records_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d descriptor sets, %0d bytes sent; %0d results checked, %0d mismatches",
             sets_sent, bytes_sent, checked, err_count);
    $display("interface %0d, endpoint %0d, extra %0d, end %0d (malformed %0d)",
             kind_seen[KIND_IFACE], kind_seen[KIND_ENDPOINT], kind_seen[KIND_EXTRA],
             kind_seen[KIND_END], malformed);
    if (err_count == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ucdp_pkg.sv
hdl/ucdp_parser.sv
hdl/ucdp_res_queue.sv
hdl/usb_config_descriptor_parser_core.sv
hdl/ucdp_checker.sv
sim/tb.sv
